// File: hdl/ape_pkg.sv
// Shared widths and status codes for the ASF payload extractor.
`timescale 1ns / 1ps
package ape_pkg;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 3;

  localparam logic [STATUS_W-1:0] ST_AUDIO     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NONE      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EOF       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_SYNC   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_VALUE = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_LEN   = 3'd5;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h82;
endpackage

// File: hdl/ape_if.sv
// Valid/ready channel interfaces for the ASF payload extractor.
`timescale 1ns / 1ps
interface ape_in_if;
  logic                        valid;
  logic                        ready;
  logic [ape_pkg::BYTE_W-1:0]  in_byte;
  logic                        stream_end;
  modport source (output valid, in_byte, stream_end, input ready);
  modport sink   (input valid, in_byte, stream_end, output ready);
endinterface

interface ape_out_if;
  logic                          valid;
  logic                          ready;
  logic                          data_valid;
  logic [ape_pkg::BYTE_W-1:0]    out_byte;
  logic                          packet_done;
  logic [ape_pkg::STATUS_W-1:0]  status;
  modport source (output valid, data_valid, out_byte, packet_done, status, input ready);
  modport sink   (input valid, data_valid, out_byte, packet_done, status, output ready);
endinterface

// File: hdl/asf_packet_payload_extractor.sv
// ASF data packet parser that extracts payload bytes of one stream.
// Usage:
//   in_if  : one data-object byte per transaction, or stream_end to flush.
//   out_if : zero or one result per input transaction: an extracted audio
//            byte (data_valid) and/or an end-of-packet flag with status.
//   cfg_*  : write the packet length (index 0) and audio_stream (index 1) while idle.
// Each byte is parsed in the cycle it is taken; its result sits in the
// output register the next cycle, and one byte is taken every cycle while
// in_if.ready is high. Field widths, zero-size fields and payload header
// chains all resolve within the cycle in which the byte is taken.
// in_if.ready stays high while the output register is empty or being taken;
// when the receiver stalls with a result held, input stops until it drains.
// Reset (synchronous, rst_n low) sets the packet length to 1, audio_stream
// to 0, empties the output register and waits for a sync byte.
// A packet ends after its configured length in bytes; a stream end reports
// end of stream and drops the packet in progress.
`timescale 1ns / 1ps
module asf_packet_payload_extractor (
  input  logic        clk,
  input  logic        rst_n,
  ape_in_if.sink      in_if,
  ape_out_if.source   out_if,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_wdata
);
  localparam logic [4:0] PH_SYNC   = 5'd0;
  localparam logic [4:0] PH_EC     = 5'd1;
  localparam logic [4:0] PH_FLAGS  = 5'd2;
  localparam logic [4:0] PH_PROP   = 5'd3;
  localparam logic [4:0] PH_LEN    = 5'd4;
  localparam logic [4:0] PH_SEQ    = 5'd5;
  localparam logic [4:0] PH_PAD    = 5'd6;
  localparam logic [4:0] PH_SEND   = 5'd7;
  localparam logic [4:0] PH_DUR    = 5'd8;
  localparam logic [4:0] PH_PCOUNT = 5'd9;
  localparam logic [4:0] PH_SID    = 5'd10;
  localparam logic [4:0] PH_MON    = 5'd11;
  localparam logic [4:0] PH_MOFF   = 5'd12;
  localparam logic [4:0] PH_REPLEN = 5'd13;
  localparam logic [4:0] PH_REPDAT = 5'd14;
  localparam logic [4:0] PH_PLEN   = 5'd15;
  localparam logic [4:0] PH_EXTRA  = 5'd16;
  localparam logic [4:0] PH_DATA   = 5'd17;
  localparam logic [4:0] PH_SKIP   = 5'd18;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_FIN  = 2'd1;
  localparam logic [1:0] ACT_AREP = 2'd2;
  localparam logic [1:0] ACT_BEGP = 2'd3;

  localparam logic CFG_PSIZE = 1'b0;
  localparam logic CFG_ASTRM = 1'b1;

  localparam logic [2:0] W_NONE = 3'd7;

  // longest chain: stream id byte, three empty fields, payload start
  localparam int CHAIN_STEPS = 9;

  // size code 0,1,2,3 -> 0,1,2,4 bytes
  function automatic logic [2:0] size_of(input logic [1:0] c);
    return (c == 2'd3) ? 3'd4 : {1'b0, c};
  endfunction

  function automatic logic [2:0] fwidth(input logic [4:0] ph, input logic [7:0] fl,
                                        input logic [7:0] pr);
    logic [2:0] w;
    w = W_NONE;
    unique case (ph)
      PH_LEN:    w = size_of(fl[6:5]);
      PH_SEQ:    w = size_of(fl[2:1]);
      PH_PAD:    w = size_of(fl[4:3]);
      PH_SEND:   w = 3'd4;
      PH_DUR:    w = 3'd2;
      PH_MON:    w = size_of(pr[5:4]);
      PH_MOFF:   w = size_of(pr[3:2]);
      PH_REPLEN: w = size_of(pr[1:0]);
      PH_PLEN:   w = 3'd2;
      default:   w = W_NONE;
    endcase
    return w;
  endfunction

  logic [31:0] pkt_len_r;
  logic [6:0]  audio_stream_r;

  logic [4:0]  phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [7:0]  prop_r, prop_nxt;
  logic [31:0] decl_r, decl_nxt;
  logic [31:0] pad_r, pad_nxt;
  logic [5:0]  pleft_r, pleft_nxt;
  logic [1:0]  ltype_r, ltype_nxt;
  logic [31:0] bleft_r, bleft_nxt;
  logic        smatch_r, smatch_nxt;
  logic        aseen_r, aseen_nxt;
  logic [2:0]  err_r, err_nxt;
  logic        rep1_r, rep1_nxt;

  logic        out_valid_r;
  logic        data_valid_r;
  logic [7:0]  out_byte_r;
  logic        done_r;
  logic [2:0]  status_r;

  logic        accept;
  logic        emit;
  logic        done;
  logic [2:0]  status_c;
  logic [1:0]  act;
  logic [31:0] fval;
  logic        go;
  logic [4:0]  go_ph;
  logic [2:0]  w;
  logic [32:0] need;
  logic [32:0] padsum;
  logic [31:0] len;
  logic [31:0] n;
  logic [7:0]  b;

  assign accept    = in_if.valid && in_if.ready;
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign b         = in_if.in_byte;

  always_comb begin
    phase_nxt  = phase_r;
    cnt_nxt    = cnt_r + 32'd1;
    acc_nxt    = acc_r;
    idx_nxt    = idx_r;
    flags_nxt  = flags_r;
    prop_nxt   = prop_r;
    decl_nxt   = decl_r;
    pad_nxt    = pad_r;
    pleft_nxt  = pleft_r;
    ltype_nxt  = ltype_r;
    bleft_nxt  = bleft_r;
    smatch_nxt = smatch_r;
    aseen_nxt  = aseen_r;
    err_nxt    = err_r;
    rep1_nxt   = rep1_r;
    emit       = 1'b0;
    act        = ACT_NONE;
    fval       = 32'd0;
    go         = 1'b0;
    go_ph      = PH_SKIP;
    need       = 33'd0;
    padsum     = 33'd0;
    len        = 32'd0;
    n          = 32'd0;
    w          = fwidth(phase_r, flags_r, prop_r);

    // step for the incoming byte
    if (w != W_NONE && w != 3'd0) begin
      acc_nxt = acc_r | ({24'd0, b} << {idx_r[1:0], 3'b000});
      idx_nxt = idx_r + 3'd1;
      if (idx_nxt >= w) begin
        act  = ACT_FIN;
        fval = acc_nxt;
      end
    end else begin
      case (phase_r)
        PH_SYNC: begin
          if (b != ape_pkg::SYNC_BYTE) begin
            if (err_nxt == 3'd0) err_nxt = ape_pkg::ST_NO_SYNC;
            go = 1'b1; go_ph = PH_SKIP;
          end else begin
            bleft_nxt = 32'd2;
            go = 1'b1; go_ph = PH_EC;
          end
        end
        PH_EC: begin
          if (bleft_nxt != 32'd0) bleft_nxt = bleft_nxt - 32'd1;
          if (bleft_nxt == 32'd0) begin go = 1'b1; go_ph = PH_FLAGS; end
        end
        PH_FLAGS: begin
          flags_nxt = b;
          go = 1'b1; go_ph = PH_PROP;
        end
        PH_PROP: begin
          prop_nxt = b;
          go = 1'b1; go_ph = PH_LEN;
        end
        PH_PCOUNT: begin
          pleft_nxt = b[5:0];
          ltype_nxt = b[7:6];
          act = ACT_BEGP;
        end
        PH_SID: begin
          smatch_nxt = (b[6:0] == audio_stream_r);
          pleft_nxt  = pleft_r - 6'd1;
          go = 1'b1; go_ph = PH_MON;
        end
        PH_REPDAT: begin
          if (bleft_nxt != 32'd0) bleft_nxt = bleft_nxt - 32'd1;
          if (bleft_nxt == 32'd0) act = ACT_AREP;
        end
        PH_EXTRA: begin
          if (bleft_r == 32'd0) act = ACT_BEGP;
          else begin go = 1'b1; go_ph = PH_DATA; end
        end
        PH_DATA: begin
          emit = smatch_r;
          if (smatch_r) aseen_nxt = 1'b1;
          if (bleft_nxt != 32'd0) bleft_nxt = bleft_nxt - 32'd1;
          if (bleft_nxt == 32'd0) act = ACT_BEGP;
        end
        default: ;
      endcase
    end

    // resolve header chains: zero-size fields and payload starts
    for (int i = 0; i < CHAIN_STEPS; i++) begin
      if (go) begin
        go        = 1'b0;
        phase_nxt = go_ph;
        acc_nxt   = 32'd0;
        idx_nxt   = 3'd0;
        if (fwidth(go_ph, flags_nxt, prop_nxt) == 3'd0) begin
          act  = ACT_FIN;
          fval = 32'd0;
        end
      end else begin
        case (act)
          ACT_FIN: begin
            act = ACT_NONE;
            case (phase_nxt)
              PH_LEN:  begin decl_nxt = fval; go = 1'b1; go_ph = PH_SEQ; end
              PH_SEQ:  begin go = 1'b1; go_ph = PH_PAD; end
              PH_PAD:  begin pad_nxt = fval; go = 1'b1; go_ph = PH_SEND; end
              PH_SEND: begin go = 1'b1; go_ph = PH_DUR; end
              PH_DUR: begin
                len = (flags_nxt[6:5] != 2'd0) ? decl_nxt : pkt_len_r;
                if (len > pkt_len_r) begin
                  if (err_nxt == 3'd0) err_nxt = ape_pkg::ST_BAD_LEN;
                  go = 1'b1; go_ph = PH_SKIP;
                end else begin
                  padsum  = {1'b0, pad_nxt} + {1'b0, pkt_len_r - len};
                  pad_nxt = padsum[32] ? 32'hFFFF_FFFF : padsum[31:0];
                  decl_nxt = pkt_len_r;
                  if (flags_nxt[0]) begin
                    go = 1'b1; go_ph = PH_PCOUNT;
                  end else begin
                    pleft_nxt = 6'd1;
                    ltype_nxt = 2'd2;
                    act = ACT_BEGP;
                  end
                end
              end
              PH_MON:  begin go = 1'b1; go_ph = PH_MOFF; end
              PH_MOFF: begin go = 1'b1; go_ph = PH_REPLEN; end
              PH_REPLEN: begin
                rep1_nxt  = (fval == 32'd1);
                bleft_nxt = fval;
                if (fval == 32'd0) act = ACT_AREP;
                else begin go = 1'b1; go_ph = PH_REPDAT; end
              end
              PH_PLEN: begin
                n = fval;
                if (rep1_nxt && n != 32'd0) begin
                  bleft_nxt = n - 32'd1; go = 1'b1; go_ph = PH_EXTRA;
                end else if (n != 32'd0) begin
                  bleft_nxt = n; go = 1'b1; go_ph = PH_DATA;
                end else act = ACT_BEGP;
              end
              default: begin go = 1'b1; go_ph = PH_SKIP; end
            endcase
          end
          ACT_AREP: begin
            act = ACT_NONE;
            if (flags_nxt[0]) begin
              if (size_of(ltype_nxt) != 3'd2) begin
                if (err_nxt == 3'd0) err_nxt = ape_pkg::ST_BAD_VALUE;
                go = 1'b1; go_ph = PH_SKIP;
              end else begin
                go = 1'b1; go_ph = PH_PLEN;
              end
            end else begin
              need = {1'b0, cnt_nxt} + {1'b0, pad_nxt};
              if (need > {1'b0, decl_nxt}) begin
                if (err_nxt == 3'd0) err_nxt = ape_pkg::ST_BAD_LEN;
                go = 1'b1; go_ph = PH_SKIP;
              end else begin
                n = decl_nxt - need[31:0];
                if (rep1_nxt && n != 32'd0) begin
                  bleft_nxt = n - 32'd1; go = 1'b1; go_ph = PH_EXTRA;
                end else if (n != 32'd0) begin
                  bleft_nxt = n; go = 1'b1; go_ph = PH_DATA;
                end else act = ACT_BEGP;
              end
            end
          end
          ACT_BEGP: begin
            act   = ACT_NONE;
            go    = 1'b1;
            go_ph = (pleft_nxt == 6'd0) ? PH_SKIP : PH_SID;
          end
          default: ;
        endcase
      end
    end

    done = (cnt_nxt >= pkt_len_r);
    if (err_nxt != 3'd0)        status_c = err_nxt;
    else if (phase_nxt != PH_SKIP) status_c = ape_pkg::ST_BAD_LEN;
    else if (aseen_nxt)         status_c = ape_pkg::ST_AUDIO;
    else                        status_c = ape_pkg::ST_NONE;

    if (in_if.stream_end) begin
      emit     = 1'b0;
      done     = 1'b1;
      status_c = ape_pkg::ST_EOF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_len_r      <= 32'd1;
      audio_stream_r <= 7'd0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_PSIZE: pkt_len_r      <= cfg_wdata;
        CFG_ASTRM: audio_stream_r <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && done)) begin
      phase_r  <= PH_SYNC;
      cnt_r    <= 32'd0;
      acc_r    <= 32'd0;
      idx_r    <= 3'd0;
      flags_r  <= 8'd0;
      prop_r   <= 8'd0;
      decl_r   <= 32'd0;
      pad_r    <= 32'd0;
      pleft_r  <= 6'd0;
      ltype_r  <= 2'd0;
      bleft_r  <= 32'd0;
      smatch_r <= 1'b0;
      aseen_r  <= 1'b0;
      err_r    <= 3'd0;
      rep1_r   <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      acc_r    <= acc_nxt;
      idx_r    <= idx_nxt;
      flags_r  <= flags_nxt;
      prop_r   <= prop_nxt;
      decl_r   <= decl_nxt;
      pad_r    <= pad_nxt;
      pleft_r  <= pleft_nxt;
      ltype_r  <= ltype_nxt;
      bleft_r  <= bleft_nxt;
      smatch_r <= smatch_nxt;
      aseen_r  <= aseen_nxt;
      err_r    <= err_nxt;
      rep1_r   <= rep1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && (emit || done)) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (emit || done)) begin
      data_valid_r <= emit;
      out_byte_r   <= emit ? b : 8'd0;
      done_r       <= done;
      status_r     <= done ? status_c : ape_pkg::ST_AUDIO;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.data_valid  = data_valid_r;
  assign out_if.out_byte    = out_byte_r;
  assign out_if.packet_done = done_r;
  assign out_if.status      = status_r;

`ifndef SYNTHESIS
  a_eof_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_if.stream_end |=> out_valid_r && done_r && !data_valid_r
      && status_r == ape_pkg::ST_EOF)
    else $error("stream end did not give an end-of-stream result");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && done |=> phase_r == PH_SYNC && cnt_r == 32'd0 && err_r == 3'd0)
    else $error("packet state not cleared after packet end");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !done_r |-> status_r == ape_pkg::ST_AUDIO && data_valid_r)
    else $error("mid-packet result without payload byte or with status");

  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !data_valid_r |-> out_byte_r == 8'd0)
    else $error("out_byte set without data_valid");

  a_count_below_size: assert property (@(posedge clk) disable iff (!rst_n)
    $past(accept) && !$past(done) |-> cnt_r < pkt_len_r || $past(cfg_we))
    else $error("packet byte count passed packet size");
`endif
endmodule

// File: test/tb.sv
// Self-checking testbench for the ASF packet payload extractor.
`timescale 1ns / 1ps
module tb;

  typedef struct packed {
    logic                         dv;
    logic [ape_pkg::BYTE_W-1:0]   ob;
    logic                         done;
    logic [ape_pkg::STATUS_W-1:0] st;
  } res_t;

  typedef enum logic [4:0] {
    P_SYNC, P_EC, P_FLAGS, P_PROP, P_LEN, P_SEQ, P_PAD, P_SEND, P_DUR, P_PCOUNT,
    P_SID, P_MON, P_MOFF, P_REPLEN, P_REPDAT, P_PLEN, P_EXTRA, P_DATA, P_SKIP
  } phase_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [7:0]  b;
    logic        e;
    logic        typed;
    res_t        res;
    logic        addr;
    logic [31:0] data;
  } row_t;

  localparam logic CFG_PKT_LEN      = 1'b0;
  localparam logic CFG_AUDIO_STREAM = 1'b1;
  localparam int   WATCHDOG_LIMIT   = 2000;
  localparam int   HOLD_CYCLES      = 300;
  localparam int   ITEM_TARGET      = 450;

  logic clk, rst_n;
  logic cfg_we, cfg_addr;
  logic [31:0] cfg_wdata;

  ape_in_if  in_if();
  ape_out_if out_if();

  asf_packet_payload_extractor DUT (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // model state
  logic [31:0] m_pkt_size;
  logic [6:0]  m_stream;
  phase_t      m_phase;
  logic [31:0] m_cnt, m_acc, m_decl, m_pad, m_left;
  logic [2:0]  m_idx, m_err;
  logic [7:0]  m_flags, m_prop;
  logic [5:0]  m_payloads;
  logic [1:0]  m_ltype;
  logic        m_match, m_audio, m_rep_one;

  res_t        expected_q[$];
  int          errors = 0;
  int          items_sent = 0;
  int          idle_cnt = 0;
  logic        row_typed;
  res_t        row_res;
  logic        idling_on = 1'b1;
  logic        hold_req = 1'b0;
  logic [7:0]  pk[$];
  logic [7:0]  m_prop_gen;

  function automatic int code_bytes(logic [1:0] c);
    return (c == 2'd3) ? 4 : int'(c);
  endfunction

  function automatic int fld_w(phase_t p);
    case (p)
      P_LEN:    return code_bytes(m_flags[6:5]);
      P_SEQ:    return code_bytes(m_flags[2:1]);
      P_PAD:    return code_bytes(m_flags[4:3]);
      P_SEND:   return 4;
      P_DUR:    return 2;
      P_MON:    return code_bytes(m_prop[5:4]);
      P_MOFF:   return code_bytes(m_prop[3:2]);
      P_REPLEN: return code_bytes(m_prop[1:0]);
      P_PLEN:   return 2;
      default:  return -1;
    endcase
  endfunction

  function automatic void abort_pkt(logic [2:0] code);
    if (m_err == 3'd0) m_err = code;
    goto_phase(P_SKIP);
  endfunction

  function automatic void next_payload();
    if (m_payloads == 6'd0) goto_phase(P_SKIP);
    else goto_phase(P_SID);
  endfunction

  function automatic void open_data(logic [31:0] n);
    if (m_rep_one && n != 0) begin
      m_left = n - 1;
      goto_phase(P_EXTRA);
    end else if (n != 0) begin
      m_left = n;
      goto_phase(P_DATA);
    end else begin
      next_payload();
    end
  endfunction

  function automatic void after_rep();
    logic [32:0] need;
    if (m_flags[0]) begin
      if (code_bytes(m_ltype) != 2) abort_pkt(ape_pkg::ST_BAD_VALUE);
      else goto_phase(P_PLEN);
    end else begin
      need = {1'b0, m_cnt} + {1'b0, m_pad};
      if (need > {1'b0, m_decl}) abort_pkt(ape_pkg::ST_BAD_LEN);
      else open_data(m_decl - need[31:0]);
    end
  endfunction

  function automatic void close_field(phase_t p, logic [31:0] v);
    logic [31:0] len;
    logic [32:0] sum;
    case (p)
      P_LEN:  begin m_decl = v; goto_phase(P_SEQ); end
      P_SEQ:  goto_phase(P_PAD);
      P_PAD:  begin m_pad = v; goto_phase(P_SEND); end
      P_SEND: goto_phase(P_DUR);
      P_DUR: begin
        len = (m_flags[6:5] != 2'd0) ? m_decl : m_pkt_size;
        if (len > m_pkt_size) begin
          abort_pkt(ape_pkg::ST_BAD_LEN);
        end else begin
          sum = {1'b0, m_pad} + {1'b0, m_pkt_size - len};
          m_pad = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
          m_decl = m_pkt_size;
          if (m_flags[0]) begin
            goto_phase(P_PCOUNT);
          end else begin
            m_payloads = 6'd1;
            m_ltype = 2'd2;
            next_payload();
          end
        end
      end
      P_MON:  goto_phase(P_MOFF);
      P_MOFF: goto_phase(P_REPLEN);
      P_REPLEN: begin
        m_rep_one = (v == 32'd1);
        m_left = v;
        if (v == 0) after_rep();
        else goto_phase(P_REPDAT);
      end
      P_PLEN: open_data(v);
      default: goto_phase(P_SKIP);
    endcase
  endfunction

  function automatic void goto_phase(phase_t p);
    m_phase = p;
    m_acc = 0;
    m_idx = 0;
    if (fld_w(p) == 0) close_field(p, 32'd0);
  endfunction

  function automatic void clear_pkt();
    m_phase = P_SYNC; m_cnt = 0; m_acc = 0; m_idx = 0; m_flags = 0; m_prop = 0;
    m_decl = 0; m_pad = 0; m_payloads = 0; m_ltype = 0; m_left = 0;
    m_match = 0; m_audio = 0; m_err = 0; m_rep_one = 0;
  endfunction

  function automatic logic consume(logic [7:0] b);
    phase_t p;
    int w;
    logic emit;
    p = m_phase;
    w = fld_w(p);
    if (w > 0) begin
      m_acc = m_acc | ({24'd0, b} << (8 * m_idx[1:0]));
      m_idx = m_idx + 3'd1;
      if (int'(m_idx) >= w) close_field(p, m_acc);
      return 1'b0;
    end
    emit = 1'b0;
    case (p)
      P_SYNC: begin
        if (b != ape_pkg::SYNC_BYTE) abort_pkt(ape_pkg::ST_NO_SYNC);
        else begin m_left = 2; goto_phase(P_EC); end
      end
      P_EC: begin
        if (m_left != 0) m_left--;
        if (m_left == 0) goto_phase(P_FLAGS);
      end
      P_FLAGS: begin m_flags = b; goto_phase(P_PROP); end
      P_PROP:  begin m_prop = b; goto_phase(P_LEN); end
      P_PCOUNT: begin
        m_payloads = b[5:0];
        m_ltype = b[7:6];
        next_payload();
      end
      P_SID: begin
        m_match = (b[6:0] == m_stream);
        m_payloads = m_payloads - 6'd1;
        goto_phase(P_MON);
      end
      P_REPDAT: begin
        if (m_left != 0) m_left--;
        if (m_left == 0) after_rep();
      end
      P_EXTRA: begin
        if (m_left == 0) next_payload();
        else goto_phase(P_DATA);
      end
      P_DATA: begin
        emit = m_match;
        if (emit) m_audio = 1'b1;
        if (m_left != 0) m_left--;
        if (m_left == 0) next_payload();
      end
      default: ;
    endcase
    return emit;
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic e);
    logic emit;
    res_t r;
    if (e) begin
      r = '{dv: 1'b0, ob: 8'd0, done: 1'b1, st: ape_pkg::ST_EOF};
      expected_q.push_back(r);
      clear_pkt();
      return;
    end
    m_cnt = m_cnt + 1;
    emit = consume(b);
    if (m_cnt >= m_pkt_size) begin
      r.dv = emit;
      r.ob = emit ? b : 8'd0;
      r.done = 1'b1;
      if (m_err != 0) r.st = m_err;
      else if (m_phase != P_SKIP) r.st = ape_pkg::ST_BAD_LEN;
      else r.st = m_audio ? ape_pkg::ST_AUDIO : ape_pkg::ST_NONE;
      expected_q.push_back(r);
      clear_pkt();
    end else if (emit) begin
      r = '{dv: 1'b1, ob: b, done: 1'b0, st: ape_pkg::ST_AUDIO};
      expected_q.push_back(r);
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // predictor update, result check and watchdog
  always @(posedge clk) begin
    int pre;
    res_t exp_r, got;
    logic moved;
    if (rst_n) begin
      moved = 1'b0;
      if (cfg_we) begin
        if (cfg_addr == CFG_PKT_LEN) m_pkt_size = cfg_wdata;
        else m_stream = cfg_wdata[6:0];
      end
      if (in_if.valid && in_if.ready) begin
        moved = 1'b1;
        pre = expected_q.size();
        predict_byte(in_if.in_byte, in_if.stream_end);
        if (row_typed) begin
          if (expected_q.size() > pre) void'(expected_q.pop_back());
          expected_q.push_back(row_res);
        end
      end
      if (out_if.valid && out_if.ready) begin
        moved = 1'b1;
        got = '{dv: out_if.data_valid, ob: out_if.out_byte,
                done: out_if.packet_done, st: out_if.status};
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected transaction dv=%0b byte=%02h done=%0b st=%0d",
                                     got.dv, got.ob, got.done, got.st);
        end else begin
          exp_r = expected_q.pop_front();
          if (got.dv !== exp_r.dv || got.ob !== exp_r.ob ||
              got.done !== exp_r.done || got.st !== exp_r.st) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp dv=%0b byte=%02h done=%0b st=%0d, got dv=%0b byte=%02h done=%0b st=%0d",
                       exp_r.dv, exp_r.ob, exp_r.done, exp_r.st,
                       got.dv, got.ob, got.done, got.st);
          end
        end
      end
      if (moved) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt > WATCHDOG_LIMIT) begin
        $display("tb: errors");
        $finish;
      end
    end
  end

  // receiver
  initial begin
    out_if.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_if.ready = 1'b1;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        out_if.ready = 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_if.ready = 1'b1;
      end
    end
  end

  task automatic send_item(logic [7:0] b, logic e, logic typed, res_t r);
    if (idling_on && $urandom_range(0, 6) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_if.in_byte = b;
    in_if.stream_end = e;
    row_typed = typed;
    row_res = r;
    in_if.valid = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] b, logic e);
    send_item(b, e, 1'b0, '0);
  endtask

  task automatic drain();
    in_if.valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic addr, logic [31:0] data);
    cfg_addr = addr;
    cfg_wdata = data;
    cfg_we = 1'b1;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic void put_le(int n, logic [31:0] v);
    for (int i = 0; i < n; i++) pk.push_back(v[8*i +: 8]);
  endfunction

  function automatic void build_payload(logic multi, logic [6:0] strm, logic [1:0] rc);
    int rl, pl;
    pk.push_back($urandom_range(0, 2) != 0 ? {1'($urandom), strm} : 8'($urandom));
    put_le(code_bytes(m_prop_gen[5:4]), $urandom);
    put_le(code_bytes(m_prop_gen[3:2]), $urandom);
    case ($urandom_range(0, 3))
      0: rl = 0;
      1: rl = 1;
      default: rl = 8;
    endcase
    if (rc == 2'd0) rl = 0;
    put_le(code_bytes(rc), 32'(rl));
    for (int i = 0; i < rl; i++) pk.push_back(8'($urandom));
    if (multi) begin
      pl = $urandom_range(0, 12);
      put_le(2, 32'(pl));
      for (int i = 0; i < pl; i++) pk.push_back(8'($urandom));
    end
  endfunction

  function automatic void build_packet(logic [31:0] ps, logic [6:0] strm);
    logic [1:0] lc, pc, sc, lt;
    logic multi;
    logic [7:0] flags;
    logic [31:0] lenv, padv;
    int n, r;
    pk.delete();
    lc = 2'($urandom); pc = 2'($urandom); sc = 2'($urandom);
    multi = 1'($urandom);
    flags = {1'($urandom), lc, pc, sc, multi};
    m_prop_gen = {2'($urandom), 2'($urandom), 2'($urandom),
                  ($urandom_range(0, 3) != 0) ? 2'd1 : 2'($urandom)};
    pk.push_back(ape_pkg::SYNC_BYTE);
    pk.push_back(8'($urandom));
    pk.push_back(8'($urandom));
    pk.push_back(flags);
    pk.push_back(m_prop_gen);
    r = $urandom_range(0, 9);
    if (r == 0) lenv = ps + $urandom_range(1, 3);
    else if (r < 3) lenv = ps - $urandom_range(0, 4);
    else lenv = ps;
    put_le(code_bytes(lc), lenv);
    put_le(code_bytes(sc), $urandom);
    padv = ($urandom_range(0, 9) == 0) ? 32'hFFFF_FFF0 + $urandom_range(0, 15)
                                       : $urandom_range(0, 4);
    put_le(code_bytes(pc), padv);
    put_le(4, $urandom);
    put_le(2, $urandom);
    if (multi) begin
      lt = ($urandom_range(0, 7) == 0) ? 2'($urandom) : 2'd2;
      n = $urandom_range(0, 4);
      pk.push_back({lt, 6'(n)});
      for (int i = 0; i < n; i++) build_payload(1'b1, strm, m_prop_gen[1:0]);
    end else begin
      build_payload(1'b0, strm, m_prop_gen[1:0]);
    end
    while (pk.size() < ps) pk.push_back(8'($urandom));
    while (pk.size() > ps) void'(pk.pop_back());
  endfunction

  row_t dir_tab[$];

  function automatic row_t item_row(logic [7:0] b, logic e, logic typed, res_t r);
    row_t x;
    x.kind = ROW_ITEM; x.b = b; x.e = e; x.typed = typed; x.res = r;
    x.addr = 1'b0; x.data = 0;
    return x;
  endfunction

  function automatic row_t cfg_row(logic addr, logic [31:0] data);
    row_t x;
    x = item_row(8'd0, 1'b0, 1'b0, '0);
    x.kind = ROW_CFG; x.addr = addr; x.data = data;
    return x;
  endfunction

  initial begin
    logic [31:0] ps;
    logic [6:0] strm;
    int cut;
    logic held;
    res_t eof_r, nosync_r, badlen_r;
    eof_r    = '{dv: 1'b0, ob: 8'd0, done: 1'b1, st: ape_pkg::ST_EOF};
    nosync_r = '{dv: 1'b0, ob: 8'd0, done: 1'b1, st: ape_pkg::ST_NO_SYNC};
    badlen_r = '{dv: 1'b0, ob: 8'd0, done: 1'b1, st: ape_pkg::ST_BAD_LEN};
    held = 1'b0;

    m_pkt_size = 32'd1;
    m_stream = 7'd0;
    clear_pkt();
    in_if.valid = 1'b0; in_if.in_byte = 8'd0; in_if.stream_end = 1'b0;
    row_typed = 1'b0; row_res = '0;
    cfg_we = 1'b0; cfg_addr = 1'b0; cfg_wdata = 32'd0;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // packet length is 1 after reset: every byte closes a packet
    dir_tab.push_back(item_row(8'h00, 1'b1, 1'b1, eof_r));
    dir_tab.push_back(item_row(ape_pkg::SYNC_BYTE, 1'b0, 1'b1, badlen_r));
    dir_tab.push_back(item_row(8'h00, 1'b0, 1'b1, nosync_r));
    dir_tab.push_back(item_row(8'hFF, 1'b0, 1'b1, nosync_r));
    dir_tab.push_back(item_row(8'h7D, 1'b0, 1'b1, nosync_r));
    dir_tab.push_back(item_row(8'hFF, 1'b1, 1'b1, eof_r));
    // largest packet, highest stream: header then a cut by stream end
    dir_tab.push_back(cfg_row(CFG_PKT_LEN, 32'hFFFF_FFFF));
    dir_tab.push_back(cfg_row(CFG_AUDIO_STREAM, 32'd127));
    dir_tab.push_back(item_row(ape_pkg::SYNC_BYTE, 1'b0, 1'b0, '0));
    dir_tab.push_back(item_row(8'h00, 1'b0, 1'b0, '0));
    dir_tab.push_back(item_row(8'hFF, 1'b0, 1'b0, '0));
    dir_tab.push_back(item_row(8'h00, 1'b0, 1'b0, '0));
    dir_tab.push_back(item_row(8'h15, 1'b0, 1'b0, '0));
    dir_tab.push_back(item_row(8'h00, 1'b1, 1'b1, eof_r));
    dir_tab.push_back(cfg_row(CFG_PKT_LEN, 32'd1));
    dir_tab.push_back(cfg_row(CFG_AUDIO_STREAM, 32'd0));
    dir_tab.push_back(item_row(ape_pkg::SYNC_BYTE, 1'b0, 1'b1, badlen_r));

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        drain();
        write_reg(dir_tab[i].addr, dir_tab[i].data);
      end else begin
        send_item(dir_tab[i].b, dir_tab[i].e, dir_tab[i].typed, dir_tab[i].res);
      end
    end

    while (items_sent < ITEM_TARGET) begin
      drain();
      if (items_sent > ITEM_TARGET - 70) idling_on = 1'b0;
      ps = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : $urandom_range(16, 100);
      case ($urandom_range(0, 5))
        0: strm = 7'd0;
        1: strm = 7'd127;
        default: strm = 7'($urandom);
      endcase
      write_reg(CFG_PKT_LEN, ps);
      write_reg(CFG_AUDIO_STREAM, {25'd0, strm});
      // long receiver stall while bytes keep coming
      if (!held) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      repeat ($urandom_range(1, 4)) begin
        if (items_sent < ITEM_TARGET) begin
          case ($urandom_range(0, 9))
            0: repeat ($urandom_range(1, 10)) send_byte(8'($urandom), 1'b0);
            1: begin
              build_packet(ps, strm);
              cut = $urandom_range(0, pk.size() - 1);
              for (int i = 0; i < cut; i++) send_byte(pk[i], 1'b0);
              send_byte(8'($urandom), 1'b1);
            end
            default: begin
              build_packet(ps, strm);
              foreach (pk[i]) send_byte(pk[i], 1'b0);
            end
          endcase
        end
      end
    end
    in_if.valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
